FILE: src/qmm_pkg.sv
// ----------------------------------------------------------------------------
// qmm_pkg
// Shared types, register indexes, reset values and helpers of the quad motor
// mixer with servo ramp.
// ----------------------------------------------------------------------------
package qmm_pkg;

   localparam int THR_W   = 11;
   localparam int CORR_W  = 11;
   localparam int VAL_W   = 12;
   localparam int MIX_W   = 14;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_THROTTLE_OFFSET   = 3'd0,
      REG_TAKEOFF_THRESHOLD = 3'd1,
      REG_MOTOR_MAX         = 3'd2,
      REG_RAMP_UP_LEVEL     = 3'd3,
      REG_RAMP_DOWN_LEVEL   = 3'd4,
      REG_SERVO_MIN         = 3'd5,
      REG_SERVO_MAX         = 3'd6
   } csr_reg_type;

   localparam logic [THR_W-1:0] RST_THROTTLE_OFFSET   = 11'd1000;
   localparam logic [VAL_W-1:0] RST_TAKEOFF_THRESHOLD = 12'd1450;
   localparam logic [VAL_W-1:0] RST_MOTOR_MAX         = 12'd2000;
   localparam logic [VAL_W-1:0] RST_RAMP_UP_LEVEL     = 12'd1800;
   localparam logic [VAL_W-1:0] RST_RAMP_DOWN_LEVEL   = 12'd1400;
   localparam logic [VAL_W-1:0] RST_SERVO_MIN         = 12'd1100;
   localparam logic [VAL_W-1:0] RST_SERVO_MAX         = 12'd2100;

   typedef struct packed {
      logic [THR_W-1:0] throttle_offset;
      logic [VAL_W-1:0] takeoff_threshold;
      logic [VAL_W-1:0] motor_max;
   } mix_cfg_type;

   function automatic logic [VAL_W-1:0] clamp_motor(input logic signed [MIX_W-1:0] v,
                                                    input logic [VAL_W-1:0] max_val);
      logic signed [MIX_W-1:0] max_ext;
      max_ext = $signed({2'b00, max_val});
      if (v >= max_ext) begin
         return max_val;
      end else if (v <= $signed(14'sd0)) begin
         return '0;
      end else begin
         return v[VAL_W-1:0];
      end
   endfunction

endpackage

FILE: src/qmm_mixer.sv
// ----------------------------------------------------------------------------
// qmm_mixer
// X-frame mixing of throttle and attitude corrections into four clamped
// motor commands, with the takeoff threshold test.
// ----------------------------------------------------------------------------
module qmm_mixer (
   input  qmm_pkg::mix_cfg_type cfg,
   input  logic [10:0]          throttle,
   input  logic signed [10:0]   roll_correction,
   input  logic signed [10:0]   pitch_correction,
   input  logic signed [10:0]   yaw_correction,
   output logic [11:0]          motor_front_a,
   output logic [11:0]          motor_front_b,
   output logic [11:0]          motor_rear_a,
   output logic [11:0]          motor_rear_b,
   output logic                 below
);
   import qmm_pkg::*;

   logic [VAL_W-1:0]        thr;
   logic signed [MIX_W-1:0] t_s;
   logic signed [MIX_W-1:0] r_s;
   logic signed [MIX_W-1:0] p_s;
   logic signed [MIX_W-1:0] y_s;
   logic signed [MIX_W-1:0] m1;
   logic signed [MIX_W-1:0] m2;
   logic signed [MIX_W-1:0] m3;
   logic signed [MIX_W-1:0] m4;

   always_comb begin
      thr   = {1'b0, throttle} + {1'b0, cfg.throttle_offset};
      t_s   = $signed({2'b00, thr});
      r_s   = MIX_W'(roll_correction);
      p_s   = MIX_W'(pitch_correction);
      y_s   = MIX_W'(yaw_correction);
      below = thr < cfg.takeoff_threshold;
      if (below) begin
         m1 = t_s;
         m2 = t_s;
         m3 = t_s;
         m4 = t_s;
      end else begin
         m1 = t_s - r_s - p_s + y_s;
         m2 = t_s + r_s + p_s + y_s;
         m3 = t_s + r_s - p_s - y_s;
         m4 = t_s - r_s + p_s - y_s;
      end
      motor_front_a = clamp_motor(m1, cfg.motor_max);
      motor_front_b = clamp_motor(m2, cfg.motor_max);
      motor_rear_a  = clamp_motor(m3, cfg.motor_max);
      motor_rear_b  = clamp_motor(m4, cfg.motor_max);
   end

endmodule

FILE: src/quad_motor_mixer_with_servo_ramp_core.sv
// ----------------------------------------------------------------------------
// quad_motor_mixer_with_servo_ramp_core
// Quadcopter X-frame motor mixer with a ramped servo position.
// ----------------------------------------------------------------------------
// Each request beat carries throttle, roll, pitch and yaw corrections and the
// auxiliary channel; each response beat carries four motor commands, the
// integrator clear flag and the servo position after that step.
// The csr channel writes one of seven registers per beat and is always ready;
// an index past the last register is ignored. Write it only while idle.
// A request is captured in an input register and the result is computed from
// it into the response register. One beat per cycle is sustained while the
// receiver takes responses: the input register takes a new beat whenever its
// content moves on to the response register, and it can hold one beat while a
// response is stalled.
// When the receiver stalls, both registers fill and req_ready falls.
// Reset restores all csr registers to their defaults, sets the servo position to
// its minimum of 1100 and empties both stages.
// ----------------------------------------------------------------------------
module quad_motor_mixer_with_servo_ramp_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [10:0]         req_throttle,
   input  logic signed [10:0]  req_roll_correction,
   input  logic signed [10:0]  req_pitch_correction,
   input  logic signed [10:0]  req_yaw_correction,
   input  logic [11:0]         req_aux_channel,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [11:0]         rsp_motor_front_a,
   output logic [11:0]         rsp_motor_front_b,
   output logic [11:0]         rsp_motor_rear_a,
   output logic [11:0]         rsp_motor_rear_b,
   output logic                rsp_clear_integrators,
   output logic [11:0]         rsp_servo_position,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [11:0]         csr_data
);
   import qmm_pkg::*;

   logic [THR_W-1:0]         throttle_offset_ff;
   logic [VAL_W-1:0]         takeoff_threshold_ff;
   logic [VAL_W-1:0]         motor_max_ff;
   logic [VAL_W-1:0]         ramp_up_level_ff;
   logic [VAL_W-1:0]         ramp_down_level_ff;
   logic [VAL_W-1:0]         servo_min_ff;
   logic [VAL_W-1:0]         servo_max_ff;
   logic [VAL_W-1:0]         servo_level_ff;
   logic [VAL_W-1:0]         servo_level_in;
   logic [VAL_W-1:0]         servo_up;

   logic                     in_valid_ff;
   logic [THR_W-1:0]         in_throttle_ff;
   logic signed [CORR_W-1:0] in_roll_ff;
   logic signed [CORR_W-1:0] in_pitch_ff;
   logic signed [CORR_W-1:0] in_yaw_ff;
   logic [VAL_W-1:0]         in_aux_ff;

   logic                     rsp_valid_ff;
   logic [VAL_W-1:0]         motor_front_a_ff;
   logic [VAL_W-1:0]         motor_front_b_ff;
   logic [VAL_W-1:0]         motor_rear_a_ff;
   logic [VAL_W-1:0]         motor_rear_b_ff;
   logic                     clear_integrators_ff;

   mix_cfg_type              mix_cfg;
   logic [VAL_W-1:0]         mix_front_a;
   logic [VAL_W-1:0]         mix_front_b;
   logic [VAL_W-1:0]         mix_rear_a;
   logic [VAL_W-1:0]         mix_rear_b;
   logic                     mix_below;
   logic                     advance;
   logic                     req_beat;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_beat  = req_valid && req_ready;

   assign mix_cfg.throttle_offset   = throttle_offset_ff;
   assign mix_cfg.takeoff_threshold = takeoff_threshold_ff;
   assign mix_cfg.motor_max         = motor_max_ff;

   qmm_mixer u_mixer (
      .cfg              (mix_cfg),
      .throttle         (in_throttle_ff),
      .roll_correction  (in_roll_ff),
      .pitch_correction (in_pitch_ff),
      .yaw_correction   (in_yaw_ff),
      .motor_front_a    (mix_front_a),
      .motor_front_b    (mix_front_b),
      .motor_rear_a     (mix_rear_a),
      .motor_rear_b     (mix_rear_b),
      .below            (mix_below)
   );

   // The up step is applied first, then the down step, as two clamped stages.
   always_comb begin
      servo_up = servo_level_ff;
      if (in_aux_ff >= ramp_up_level_ff) begin
         if (servo_level_ff >= servo_max_ff) begin
            servo_up = servo_max_ff;
         end else begin
            servo_up = servo_level_ff + 12'd1;
         end
      end
      servo_level_in = servo_up;
      if (in_aux_ff <= ramp_down_level_ff) begin
         if (servo_up <= servo_min_ff) begin
            servo_level_in = servo_min_ff;
         end else begin
            servo_level_in = servo_up - 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         throttle_offset_ff   <= RST_THROTTLE_OFFSET;
         takeoff_threshold_ff <= RST_TAKEOFF_THRESHOLD;
         motor_max_ff         <= RST_MOTOR_MAX;
         ramp_up_level_ff     <= RST_RAMP_UP_LEVEL;
         ramp_down_level_ff   <= RST_RAMP_DOWN_LEVEL;
         servo_min_ff         <= RST_SERVO_MIN;
         servo_max_ff         <= RST_SERVO_MAX;
      end else if (csr_valid) begin
         case (csr_index)
            REG_THROTTLE_OFFSET:   throttle_offset_ff   <= csr_data[THR_W-1:0];
            REG_TAKEOFF_THRESHOLD: takeoff_threshold_ff <= csr_data;
            REG_MOTOR_MAX:         motor_max_ff         <= csr_data;
            REG_RAMP_UP_LEVEL:     ramp_up_level_ff     <= csr_data;
            REG_RAMP_DOWN_LEVEL:   ramp_down_level_ff   <= csr_data;
            REG_SERVO_MIN:         servo_min_ff         <= csr_data;
            REG_SERVO_MAX:         servo_max_ff         <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         servo_level_ff <= RST_SERVO_MIN;
      end else begin
         if (req_beat) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            servo_level_ff <= servo_level_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_throttle_ff <= req_throttle;
         in_roll_ff     <= req_roll_correction;
         in_pitch_ff    <= req_pitch_correction;
         in_yaw_ff      <= req_yaw_correction;
         in_aux_ff      <= req_aux_channel;
      end
      if (advance) begin
         motor_front_a_ff     <= mix_front_a;
         motor_front_b_ff     <= mix_front_b;
         motor_rear_a_ff      <= mix_rear_a;
         motor_rear_b_ff      <= mix_rear_b;
         clear_integrators_ff <= mix_below;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_motor_front_a     = motor_front_a_ff;
   assign rsp_motor_front_b     = motor_front_b_ff;
   assign rsp_motor_rear_a      = motor_rear_a_ff;
   assign rsp_motor_rear_b      = motor_rear_b_ff;
   assign rsp_clear_integrators = clear_integrators_ff;
   assign rsp_servo_position    = servo_level_ff;

   a_idle_motors_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && clear_integrators_ff |->
         motor_front_a_ff == motor_front_b_ff && motor_front_a_ff == motor_rear_a_ff &&
         motor_front_a_ff == motor_rear_b_ff)
      else $error("Integrator clear with unequal motor commands.");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("Request taken while both stages are full and stalled.");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("Request refused while the input register is empty.");

   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> servo_level_ff == RST_SERVO_MIN && !rsp_valid_ff && !in_valid_ff)
      else $error("Servo level or stage state wrong after reset.");

endmodule
